// ===== rtl/core/mlft_pkg.sv =====
// Shared types and constants for the MAC learning forward table.
// Used by the table memory, the scan unit, the core and the checker.
package mlft_pkg;

    localparam int MAC_W   = 48;
    localparam int PORT_W  = 3;
    localparam int MASK_W  = 8;
    localparam int STAMP_W = 32;
    localparam int LIDX_W  = 6;
    localparam int ACT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_REFRESH = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FILL    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_EVICT   = 2'd2;

    typedef struct packed {
        logic clear;
        logic eval;
    } scan_ctrl_t;

endpackage

// ===== rtl/core/mlft_table.sv =====
// Table memory: MAC, port and stamp of every entry in one word.
// One write port, one read port with registered read data. Uses mlft_pkg.
module mlft_table
    import mlft_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int IDX_W         = 6
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [MAC_W-1:0]   wr_mac,
    input  logic [PORT_W-1:0]  wr_port,
    input  logic [STAMP_W-1:0] wr_stamp,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [MAC_W-1:0]   rd_mac,
    output logic [PORT_W-1:0]  rd_port,
    output logic [STAMP_W-1:0] rd_stamp
);

    localparam int WORD_W = MAC_W + PORT_W + STAMP_W;

    logic [WORD_W-1:0] mem [TABLE_ENTRIES];
    logic [WORD_W-1:0] rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_mac, wr_port, wr_stamp};
        end
        rd_word_reg <= mem[rd_addr];
    end

    assign rd_mac   = rd_word_reg[WORD_W-1 -: MAC_W];
    assign rd_port  = rd_word_reg[STAMP_W +: PORT_W];
    assign rd_stamp = rd_word_reg[STAMP_W-1:0];

endmodule

// ===== rtl/core/mlft_scan.sv =====
// Shared compare unit: takes one table entry per cycle and keeps the first
// source match, the destination match and the oldest entry. Uses mlft_pkg.
module mlft_scan
    import mlft_pkg::*;
#(
    parameter int IDX_W = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  scan_ctrl_t         ctrl,
    input  logic [IDX_W-1:0]   idx,
    input  logic [MAC_W-1:0]   mac,
    input  logic [PORT_W-1:0]  port,
    input  logic [STAMP_W-1:0] stamp,
    input  logic [MAC_W-1:0]   src_mac,
    input  logic [MAC_W-1:0]   dst_mac,
    input  logic [STAMP_W-1:0] now,
    output logic               src_hit,
    output logic [IDX_W-1:0]   src_idx,
    output logic               dst_hit,
    output logic [IDX_W-1:0]   dst_idx,
    output logic [PORT_W-1:0]  dst_port,
    output logic [IDX_W-1:0]   old_idx
);

    logic               src_hit_reg;
    logic [IDX_W-1:0]   src_idx_reg;
    logic               dst_hit_reg;
    logic [IDX_W-1:0]   dst_idx_reg;
    logic [PORT_W-1:0]  dst_port_reg;
    logic [IDX_W-1:0]   old_idx_reg;
    logic [STAMP_W-1:0] old_age_reg;
    logic [STAMP_W-1:0] age;

    // wrap-safe age of the entry under test
    assign age = now - stamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_hit_reg  <= 1'b0;
            src_idx_reg  <= '0;
            dst_hit_reg  <= 1'b0;
            dst_idx_reg  <= '0;
            dst_port_reg <= '0;
            old_idx_reg  <= '0;
            old_age_reg  <= '0;
        end
        else if (ctrl.clear)
        begin
            src_hit_reg <= 1'b0;
            dst_hit_reg <= 1'b0;
            old_idx_reg <= '0;
            old_age_reg <= '0;
        end
        else if (ctrl.eval)
        begin
            if (!src_hit_reg && mac == src_mac)
            begin
                src_hit_reg <= 1'b1;
                src_idx_reg <= idx;
            end
            if (!dst_hit_reg && mac == dst_mac)
            begin
                dst_hit_reg  <= 1'b1;
                dst_idx_reg  <= idx;
                dst_port_reg <= port;
            end
            // strictly older only, so the lowest index wins a tie
            if (idx == '0 || age > old_age_reg)
            begin
                old_idx_reg <= idx;
                old_age_reg <= age;
            end
        end
    end

    assign src_hit  = src_hit_reg;
    assign src_idx  = src_idx_reg;
    assign dst_hit  = dst_hit_reg;
    assign dst_idx  = dst_idx_reg;
    assign dst_port = dst_port_reg;
    assign old_idx  = old_idx_reg;

endmodule

// ===== rtl/core/mac_learning_forward_table_core.sv =====
// MAC learning forward table: learns each frame's source and forwards by
// destination. Depends on mlft_pkg, mlft_table and mlft_scan.
//
// Input channel (in_valid/in_stall): one frame header per transaction with
// src_port, src_mac and dst_mac. Output channel (out_valid/out_stall): one
// result per header with dest_hit, dest_mask, learn_action, learn_index.
// The block takes one header at a time and holds in_stall high while it
// works on it. Entries are filled from index 0 upward and never dropped, so
// a fill count marks the valid entries and the scan covers only those.
// The scan reads one entry per cycle from the table memory's single read
// port into one shared compare unit; a header passes through the scan,
// decide and finish states from acceptance to result, and the next header is
// taken in the cycle after the result is loaded.
// The result sits in an output register: while the receiver stalls it holds
// there and the next header may be accepted and scanned, but its result
// waits until the register is taken.
// Reset clears the fill count, the frame counter and both valid flags;
// the table memory needs no clearing pass.
module mac_learning_forward_table_core
    import mlft_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int NUM_PORTS     = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [PORT_W-1:0] src_port,
    input  logic [MAC_W-1:0]  src_mac,
    input  logic [MAC_W-1:0]  dst_mac,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              dest_hit,
    output logic [MASK_W-1:0] dest_mask,
    output logic [ACT_W-1:0]  learn_action,
    output logic [LIDX_W-1:0] learn_index
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);
    localparam logic [MASK_W-1:0] PORT_SET = (NUM_PORTS >= MASK_W) ? {MASK_W{1'b1}}
                                           : MASK_W'((16'd1 << NUM_PORTS) - 16'd1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [STAMP_W-1:0] fc_reg, fc_next;
    logic [PORT_W-1:0]  sport_reg, sport_next;
    logic [MAC_W-1:0]   smac_reg, smac_next;
    logic [MAC_W-1:0]   dmac_reg, dmac_next;
    logic               res_hit_reg, res_hit_next;
    logic [MASK_W-1:0]  res_mask_reg, res_mask_next;
    logic [ACT_W-1:0]   res_act_reg, res_act_next;
    logic [LIDX_W-1:0]  res_idx_reg, res_idx_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_hit_reg, out_hit_next;
    logic [MASK_W-1:0]  out_mask_reg, out_mask_next;
    logic [ACT_W-1:0]   out_act_reg, out_act_next;
    logic [LIDX_W-1:0]  out_idx_reg, out_idx_next;

    scan_ctrl_t         scan_ctrl;
    logic [MAC_W-1:0]   rd_mac;
    logic [PORT_W-1:0]  rd_port;
    logic [STAMP_W-1:0] rd_stamp;
    logic               s_src_hit, s_dst_hit;
    logic [IDX_W-1:0]   s_src_idx, s_dst_idx, s_old_idx;
    logic [PORT_W-1:0]  s_dst_port;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [ACT_W-1:0]   act;
    logic [IDX_W+LIDX_W-1:0] idx_wide;
    logic               in_accept;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);

    assign scan_ctrl.clear = in_accept;
    assign scan_ctrl.eval  = pend_reg;

    mlft_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_idx),
        .wr_mac   (smac_reg),
        .wr_port  (sport_reg),
        .wr_stamp (fc_reg),
        .rd_addr  (cnt_reg[IDX_W-1:0]),
        .rd_mac   (rd_mac),
        .rd_port  (rd_port),
        .rd_stamp (rd_stamp)
    );

    mlft_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (scan_ctrl),
        .idx      (rd_idx_reg),
        .mac      (rd_mac),
        .port     (rd_port),
        .stamp    (rd_stamp),
        .src_mac  (smac_reg),
        .dst_mac  (dmac_reg),
        .now      (fc_reg),
        .src_hit  (s_src_hit),
        .src_idx  (s_src_idx),
        .dst_hit  (s_dst_hit),
        .dst_idx  (s_dst_idx),
        .dst_port (s_dst_port),
        .old_idx  (s_old_idx)
    );

    // choose the entry that learning writes
    always_comb
    begin
        if (s_src_hit)
        begin
            act    = ACT_REFRESH;
            wr_idx = s_src_idx;
        end
        else if (fill_reg != FULL_COUNT)
        begin
            act    = ACT_FILL;
            wr_idx = fill_reg[IDX_W-1:0];
        end
        else
        begin
            act    = ACT_EVICT;
            wr_idx = s_old_idx;
        end
    end

    assign wr_en    = (state_reg == ST_DECIDE);
    assign idx_wide = {{LIDX_W{1'b0}}, wr_idx};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        rd_idx_next    = rd_idx_reg;
        fill_next      = fill_reg;
        fc_next        = fc_reg;
        sport_next     = sport_reg;
        smac_next      = smac_reg;
        dmac_next      = dmac_reg;
        res_hit_next   = res_hit_reg;
        res_mask_next  = res_mask_reg;
        res_act_next   = res_act_reg;
        res_idx_next   = res_idx_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_mask_next  = out_mask_reg;
        out_act_next   = out_act_reg;
        out_idx_next   = out_idx_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sport_next = src_port;
                    smac_next  = src_mac;
                    dmac_next  = dst_mac;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg < fill_reg)
                begin
                    pend_next   = 1'b1;
                    rd_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next    = cnt_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (act == ACT_FILL)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                fc_next      = fc_reg + 1'b1;
                res_act_next = act;
                res_idx_next = idx_wide[LIDX_W-1:0];
                // lookup after learning: the written entry now holds the source
                if (dmac_reg == smac_reg)
                begin
                    res_hit_next  = 1'b1;
                    res_mask_next = (MASK_W'(1) << sport_reg) & PORT_SET;
                end
                else if (s_dst_hit && s_dst_idx != wr_idx)
                begin
                    res_hit_next  = 1'b1;
                    res_mask_next = (MASK_W'(1) << s_dst_port) & PORT_SET;
                end
                else
                begin
                    res_hit_next  = 1'b0;
                    res_mask_next = PORT_SET & ~(MASK_W'(1) << sport_reg);
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = res_hit_reg;
                    out_mask_next  = res_mask_reg;
                    out_act_next   = res_act_reg;
                    out_idx_next   = res_idx_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            rd_idx_reg    <= '0;
            fill_reg      <= '0;
            fc_reg        <= '0;
            sport_reg     <= '0;
            smac_reg      <= '0;
            dmac_reg      <= '0;
            res_hit_reg   <= 1'b0;
            res_mask_reg  <= '0;
            res_act_reg   <= ACT_REFRESH;
            res_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_mask_reg  <= '0;
            out_act_reg   <= ACT_REFRESH;
            out_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            rd_idx_reg    <= rd_idx_next;
            fill_reg      <= fill_next;
            fc_reg        <= fc_next;
            sport_reg     <= sport_next;
            smac_reg      <= smac_next;
            dmac_reg      <= dmac_next;
            res_hit_reg   <= res_hit_next;
            res_mask_reg  <= res_mask_next;
            res_act_reg   <= res_act_next;
            res_idx_reg   <= res_idx_next;
            out_valid_reg <= out_valid_next;
            out_hit_reg   <= out_hit_next;
            out_mask_reg  <= out_mask_next;
            out_act_reg   <= out_act_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dest_hit     = out_hit_reg;
    assign dest_mask    = out_mask_reg;
    assign learn_action = out_act_reg;
    assign learn_index  = out_idx_reg;

endmodule

// ===== rtl/core/mlft_checker.sv =====
// Port-level checks for mac_learning_forward_table_core, bound to the top.
// Depends on mlft_pkg for field widths and learn action codes.
module mlft_checker
    import mlft_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic              dest_hit,
    input logic [MASK_W-1:0] dest_mask,
    input logic [ACT_W-1:0]  learn_action,
    input logic [LIDX_W-1:0] learn_index
);

    // one header at a time: busy right after a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a header is in progress");

    // the scan, decide and finish states lie between input and result, so no result appears right after input
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared one cycle after input");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (learn_action == ACT_REFRESH || learn_action == ACT_FILL
                       || learn_action == ACT_EVICT))
    else $error("undefined learn action");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(dest_hit)
            && $stable(dest_mask) && $stable(learn_action) && $stable(learn_index)))
    else $error("stalled result changed");

endmodule

bind mac_learning_forward_table_core mlft_checker u_mlft_checker (.*);

// ===== bench/mac_learning_forward_table_core_tb.sv =====
// Testbench for mac_learning_forward_table_core: directed and random frame headers
// against a scoreboard that learns and forwards in step with the table.
// Depends on mlft_pkg and the core RTL only.
module mac_learning_forward_table_core_tb;
    import mlft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ENTRIES = 64;
    localparam int NUM_PORTS     = 8;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int TAIL_CYCLES   = 80;
    localparam int POOL_MAX      = 256;

    typedef struct packed {
        logic              hit;
        logic [MASK_W-1:0] mask;
        logic [ACT_W-1:0]  action;
        logic [LIDX_W-1:0] index;
    } fwd_result_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [PORT_W-1:0] src_port     = '0;
    logic [MAC_W-1:0]  src_mac      = '0;
    logic [MAC_W-1:0]  dst_mac      = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic              dest_hit;
    logic [MASK_W-1:0] dest_mask;
    logic [ACT_W-1:0]  learn_action;
    logic [LIDX_W-1:0] learn_index;

    // Scoreboard copy of the forwarding table
    logic [MAC_W-1:0]   tbl_mac   [TABLE_ENTRIES];
    logic [PORT_W-1:0]  tbl_port  [TABLE_ENTRIES];
    bit                 tbl_used  [TABLE_ENTRIES];
    logic [STAMP_W-1:0] tbl_stamp [TABLE_ENTRIES];
    logic [STAMP_W-1:0] seq_count = '0;
    int                 tbl_count = 0;

    fwd_result_t fwd_expect_q[$];

    logic [MAC_W-1:0] mac_pool [POOL_MAX];
    int  pool_size   = 1;
    bit  valid_now   = 1'b0;
    bit  no_gaps     = 1'b0;
    int  errors      = 0;
    int  cycle_count = 0;
    int  items_sent  = 0;
    int  n_refresh   = 0;
    int  n_fill      = 0;
    int  n_evict     = 0;
    int  n_hit       = 0;
    int  n_flood     = 0;

    int  stall_seg   = 0;
    bit  stall_on    = 1'b0;
    int  stall_run   = 0;
    int  stall_pick;

    mac_learning_forward_table_core #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NUM_PORTS     (NUM_PORTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .src_port     (src_port),
        .src_mac      (src_mac),
        .dst_mac      (dst_mac),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dest_hit     (dest_hit),
        .dest_mask    (dest_mask),
        .learn_action (learn_action),
        .learn_index  (learn_index)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, fwd_expect_q.size());
            $display("mac_learning_forward_table_core: mismatch");
            $finish;
        end
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[MAC_W-1:0];
    endfunction

    function automatic int find_entry(input logic [MAC_W-1:0] mac);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_used[i] && tbl_mac[i] == mac)
                return i;
        return -1;
    endfunction

    // Age is counter minus stamp modulo 2^32; strict compare keeps the lowest index on ties
    function automatic int oldest_entry();
        logic [STAMP_W-1:0] age;
        logic [STAMP_W-1:0] best;
        int pick;
        pick = 0;
        best = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            age = seq_count - tbl_stamp[i];
            if (i == 0 || age > best)
            begin
                best = age;
                pick = i;
            end
        end
        return pick;
    endfunction

    function automatic fwd_result_t learn_and_forward(input logic [PORT_W-1:0] port,
                                                      input logic [MAC_W-1:0]  smac,
                                                      input logic [MAC_W-1:0]  dmac);
        fwd_result_t       res;
        logic [MASK_W-1:0] all_ports;
        int                slot;
        int                dpos;
        all_ports = '0;
        for (int p = 0; p < NUM_PORTS && p < MASK_W; p++)
            all_ports[p] = 1'b1;
        slot = find_entry(smac);
        if (slot >= 0)
            res.action = ACT_REFRESH;
        else
        begin
            for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                if (!tbl_used[i])
                    slot = i;
            if (slot >= 0)
            begin
                res.action = ACT_FILL;
                tbl_count++;
            end
            else
            begin
                slot = oldest_entry();
                res.action = ACT_EVICT;
            end
        end
        tbl_mac[slot]   = smac;
        tbl_port[slot]  = port;
        tbl_stamp[slot] = seq_count;
        tbl_used[slot]  = 1'b1;
        seq_count       = seq_count + 1'b1;
        // Lookup runs after learning, so source equal to destination hits itself
        dpos = find_entry(dmac);
        if (dpos >= 0)
        begin
            res.hit  = 1'b1;
            res.mask = (MASK_W'(1) << tbl_port[dpos]) & all_ports;
        end
        else
        begin
            res.hit  = 1'b0;
            res.mask = all_ports & ~(MASK_W'(1) << port);
        end
        res.index = LIDX_W'(slot);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Keep one nonblocking write of in_valid per step
    task automatic set_valid(input bit v);
        if (v != valid_now)
        begin
            in_valid  <= v;
            valid_now = v;
        end
    endtask

    task automatic send_header(input logic [PORT_W-1:0] port,
                               input logic [MAC_W-1:0]  smac,
                               input logic [MAC_W-1:0]  dmac);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            set_valid(1'b0);
            repeat (gap) @(posedge clk);
        end
        src_port <= port;
        src_mac  <= smac;
        dst_mac  <= dmac;
        set_valid(1'b1);
        do
            @(posedge clk);
        while (in_stall);
        fwd_expect_q.push_back(learn_and_forward(port, smac, dmac));
        items_sent++;
    endtask

    task automatic wait_for_drain();
        set_valid(1'b0);
        while (fwd_expect_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Receiver: each segment is picked at random to have no stall or random stalls
    always @(posedge clk)
    begin
        if (stall_seg == 0)
        begin
            stall_seg = $urandom_range(50, 400);
            stall_on  = ($urandom_range(0, 3) != 0);
        end
        else
            stall_seg--;
        if (!stall_on)
            out_stall <= 1'b0;
        else if (stall_run > 0)
        begin
            stall_run--;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 60)
                out_stall <= 1'b0;
            else if (stall_pick < 95)
            begin
                stall_run = $urandom_range(0, 3);
                out_stall <= 1'b1;
            end
            else
            begin
                stall_run = $urandom_range(15, 40);
                out_stall <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        fwd_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (fwd_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result hit %0b mask %02h action %0d index %0d",
                         $time, dest_hit, dest_mask, learn_action, learn_index);
                errors++;
            end
            else
            begin
                want = fwd_expect_q.pop_front();
                if (dest_hit !== want.hit)
                begin
                    $display("%0t: dest_hit expected %0b actual %0b", $time, want.hit, dest_hit);
                    errors++;
                end
                if (dest_mask !== want.mask)
                begin
                    $display("%0t: dest_mask expected %02h actual %02h",
                             $time, want.mask, dest_mask);
                    errors++;
                end
                if (learn_action !== want.action)
                begin
                    $display("%0t: learn_action expected %0d actual %0d",
                             $time, want.action, learn_action);
                    errors++;
                end
                if (learn_index !== want.index)
                begin
                    $display("%0t: learn_index expected %0d actual %0d",
                             $time, want.index, learn_index);
                    errors++;
                end
                case (want.action)
                    ACT_REFRESH: n_refresh++;
                    ACT_FILL:    n_fill++;
                    default:     n_evict++;
                endcase
                if (want.hit)
                    n_hit++;
                else
                    n_flood++;
            end
        end
    end

    // Extremes of ports and addresses, refresh, index zero hits, source equal to destination
    task automatic test_basic_learning();
        send_header(3'd0, 48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF);
        send_header(3'd7, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0000);
        send_header(3'd5, 48'hAAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA);
        send_header(3'd3, 48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF);
        send_header(3'd2, 48'h5555_5555_5555, 48'h0000_0000_0000);
        send_header(3'd7, 48'h8000_0000_0000, 48'h0000_0000_0001);
        send_header(3'd0, 48'h0000_0000_0001, 48'h8000_0000_0000);
        send_header(3'd6, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_header(3'd1, 48'h0123_4567_89AB, 48'hFEDC_BA98_7654);
        send_header(3'd4, 48'hFEDC_BA98_7654, 48'h0123_4567_89AB);
    endtask

    // Fill every entry, then evict; a refresh saves the oldest and moves eviction on
    task automatic test_fill_and_evict();
        int               slot;
        logic [MAC_W-1:0] victim;
        while (tbl_count < TABLE_ENTRIES)
            send_header(PORT_W'($urandom_range(0, 7)), rand_mac(), rand_mac());
        repeat (4)
        begin
            victim = tbl_mac[oldest_entry()];
            send_header(PORT_W'($urandom_range(0, 7)), rand_mac(), victim);
        end
        slot = oldest_entry();
        send_header(3'd2, tbl_mac[slot], tbl_mac[slot]);
        victim = tbl_mac[oldest_entry()];
        send_header(3'd5, rand_mac(), victim);
        send_header(3'd6, victim, tbl_mac[slot]);
    endtask

    task automatic fill_pool(input int n);
        pool_size = n;
        for (int i = 0; i < n; i++)
            mac_pool[i] = rand_mac();
    endtask

    task automatic send_pool_item();
        int               r;
        logic [PORT_W-1:0] port;
        logic [MAC_W-1:0]  smac;
        logic [MAC_W-1:0]  dmac;
        r    = $urandom_range(0, 99);
        port = PORT_W'($urandom_range(0, 7));
        smac = mac_pool[$urandom_range(0, pool_size - 1)];
        dmac = mac_pool[$urandom_range(0, pool_size - 1)];
        if (r >= 65 && r < 80)
            dmac = rand_mac();
        else if (r >= 80 && r < 90)
            smac = rand_mac();
        else if (r >= 90)
            dmac = smac;
        send_header(port, smac, dmac);
    endtask

    task automatic test_random_traffic(input int n, input int pool_n);
        fill_pool(pool_n);
        for (int k = 0; k < n; k++)
        begin
            if (k == n / 2)
                wait_for_drain();
            send_pool_item();
        end
    endtask

    task automatic test_back_to_back(input int n);
        no_gaps = 1'b1;
        repeat (n) send_pool_item();
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_learning();
        wait_for_drain();
        test_fill_and_evict();
        test_random_traffic(300, 40);
        wait_for_drain();
        test_back_to_back(60);
        test_random_traffic(250, 96);
        wait_for_drain();
        test_random_traffic(200, 200);

        set_valid(1'b0);
        while (fwd_expect_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d headers: %0d refreshed, %0d filled, %0d evicted entries",
                 items_sent, n_refresh, n_fill, n_evict);
        $display("lookups: %0d forwarded to one port, %0d flooded; %0d field errors",
                 n_hit, n_flood, errors);
        if (errors == 0)
            $display("mac_learning_forward_table_core: match");
        else
            $display("mac_learning_forward_table_core: mismatch");
        $finish;
    end

endmodule
